// ===== sv/spft_pkg.sv =====
// Shared types, request codes and a helper function of the subscriber prefix filter table.
package spft_pkg;

    localparam int DIGITS_W   = 60;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int REQ_W      = 3;
    localparam int NIBBLES    = DIGITS_W / 4;
    localparam int MAX_DIGITS = 15;

    localparam logic [REQ_W-1:0] REQ_MATCH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DIGITS_W-1:0] digits;
        logic [LEN_W-1:0]    length;
        logic                exact;
    } entry_t;

    typedef struct packed {
        logic eq;
        logic hit;
    } match_t;

    // Keeps the leading len nibbles of a digit word, first digit on top.
    function automatic logic [DIGITS_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [DIGITS_W-1:0] m;
        m = '0;
        for (int j = 0; j < NIBBLES; j++)
        begin
            if (LEN_W'(j) < len)
            begin
                m[DIGITS_W-1-4*j -: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/spft_if.sv =====
// Request and response channel interfaces of the subscriber prefix filter table.
interface spft_req_if
    import spft_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [DIGITS_W-1:0] number_digits;
    logic [LEN_W-1:0]    number_length;
    logic                exact_flag;
    logic [IDX_W-1:0]    entry_index;

    modport source (
        output valid, req_type, number_digits, number_length, exact_flag, entry_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, number_digits, number_length, exact_flag, entry_index,
        output ready
    );
endinterface

interface spft_rsp_if
    import spft_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                status;
    logic                matched;
    logic [DIGITS_W-1:0] entry_digits;
    logic [LEN_W-1:0]    entry_length;
    logic                entry_exact;
    logic [COUNT_W-1:0]  filter_count;

    modport source (
        output valid, status, matched, entry_digits, entry_length, entry_exact, filter_count,
        input  ready
    );
    modport sink (
        input  valid, status, matched, entry_digits, entry_length, entry_exact, filter_count,
        output ready
    );
endinterface

// ===== sv/spft_cell.sv =====
// One table cell: holds one filter entry and takes its neighbor's entry on each shift.
module spft_cell
    import spft_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  entry_t din,
    output entry_t dout
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

// ===== sv/spft_match.sv =====
// Compare unit at the head of the chain: equal-string and filter-hit tests.
module spft_match
    import spft_pkg::*;
(
    input  entry_t              head,
    input  logic [DIGITS_W-1:0] digits,
    input  logic [LEN_W-1:0]    length,
    output match_t              result
);

    logic                eq;
    logic [DIGITS_W-1:0] diff;

    assign eq   = (head.length == length) && (head.digits == digits);
    assign diff = (digits ^ head.digits) & lead_mask(head.length);

    always_comb
    begin
        result.eq  = eq;
        result.hit = 1'b0;
        if (head.length != '0)
        begin
            if (head.exact)
            begin
                result.hit = eq;
            end
            else if (head.length <= length)
            begin
                result.hit = (diff == '0);
            end
        end
    end

endmodule

// ===== sv/subscriber_prefix_filter_table_unit.sv =====
// Top level of the subscriber prefix filter table: control sequencer and ring of entry cells.
//
// Requests arrive on the req channel and each yields exactly one beat on the rsp channel.
// A request kind selects match, add, remove, clear or read of an entry by position.
// The entries sit in a ring of MAX_ENTRIES cells; for every request the ring makes one
// full turn, one cell per cycle, past a single compare unit at its head, which tests,
// updates, appends or drops the passing entry. Removal writes back the entry behind the
// head, so later entries close the gap in the same turn.
// One request is in flight at a time; a new one is taken only after the ring has made its full turn.
// The response sits in an output register; a new request is accepted while it waits.
// If the receiver stalls, the next finished response waits in the sequencer until the
// register frees up, and no further request is taken meanwhile.
// Reset empties the table (count zero) and drops any pending response; the stored
// entries themselves are not cleared, as only positions below the count are ever read.
module subscriber_prefix_filter_table_unit
    import spft_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    spft_req_if.sink  req,
    spft_rsp_if.source rsp
);

    localparam int K_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int T_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW  = (T_W > IDX_W) ? T_W : IDX_W;
    localparam int LA  = (MAX_ENTRIES > 1) ? 1 : 0;

    state_t              state_reg, state_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [T_W-1:0]      total_reg, total_next;
    logic                found_reg, found_next;
    logic                matched_reg, matched_next;
    entry_t              rd_reg, rd_next;

    logic [REQ_W-1:0]    op_reg;
    logic [DIGITS_W-1:0] dig_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                exact_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic                rsp_valid_reg;
    logic                status_reg, status_next;
    logic                rmatched_reg, rmatched_next;
    entry_t              rentry_reg, rentry_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                load_out;

    logic [LEN_W-1:0]    len_sat;
    logic [DIGITS_W-1:0] dig_norm;
    logic                accept;

    entry_t              chain [MAX_ENTRIES];
    entry_t              head;
    entry_t              wb;
    match_t              mres;
    logic                shift;

    logic [CW-1:0]       k_ext, idx_ext, total_ext;
    logic                in_tab;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign shift     = (state_reg == ST_RUN);

    assign len_sat  = (req.number_length > LEN_W'(MAX_DIGITS)) ?
                      LEN_W'(MAX_DIGITS) : req.number_length;
    assign dig_norm = req.number_digits & lead_mask(len_sat);

    // Ring of cells: each hands its entry toward the head; the tail takes the write-back.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t din;
        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign din = wb;
        end
        else
        begin : g_mid
            assign din = chain[i+1];
        end
        spft_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .din   (din),
            .dout  (chain[i])
        );
    end

    assign head = chain[0];

    spft_match u_match (
        .head   (head),
        .digits (dig_reg),
        .length (len_reg),
        .result (mres)
    );

    assign k_ext     = CW'(k_reg);
    assign idx_ext   = CW'(idx_reg);
    assign total_ext = CW'(total_reg);
    assign in_tab    = (k_ext < total_ext);

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        total_next    = total_reg;
        found_next    = found_reg;
        matched_next  = matched_reg;
        rd_next       = rd_reg;
        wb            = head;
        load_out      = 1'b0;
        status_next   = 1'b0;
        rmatched_next = 1'b0;
        rentry_next   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next   = ST_RUN;
                    found_next   = 1'b0;
                    matched_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                case (op_reg)
                    REQ_MATCH:
                    begin
                        if (len_reg != '0 && in_tab && mres.hit)
                        begin
                            matched_next = 1'b1;
                        end
                    end
                    REQ_ADD:
                    begin
                        if (len_reg != '0)
                        begin
                            if (in_tab && mres.eq && !found_reg)
                            begin
                                wb.exact   = exact_reg;
                                found_next = 1'b1;
                            end
                            // The first free slot passes the head after every used one.
                            if (k_ext == total_ext && !found_reg)
                            begin
                                wb.digits  = dig_reg;
                                wb.length  = len_reg;
                                wb.exact   = exact_reg;
                                found_next = 1'b1;
                            end
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (len_reg != '0)
                        begin
                            if (found_reg || (in_tab && mres.eq))
                            begin
                                wb         = chain[LA];
                                found_next = 1'b1;
                            end
                        end
                    end
                    REQ_READ:
                    begin
                        if (k_ext == idx_ext)
                        begin
                            rd_next = head;
                        end
                    end
                    default:
                    begin
                        wb = head;
                    end
                endcase

                if (k_reg == K_W'(MAX_ENTRIES - 1))
                begin
                    k_next     = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end
            ST_FINISH:
            begin
                case (op_reg)
                    REQ_MATCH:
                    begin
                        rmatched_next = matched_reg;
                    end
                    REQ_ADD:
                    begin
                        if (len_reg == '0 || !found_reg)
                        begin
                            status_next = 1'b1;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (len_reg == '0 || !found_reg)
                        begin
                            status_next = 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        status_next = 1'b0;
                    end
                    REQ_READ:
                    begin
                        if (idx_ext >= total_ext)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            rentry_next = rd_reg;
                        end
                    end
                    default:
                    begin
                        status_next = 1'b1;
                    end
                endcase

                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == REQ_CLEAR)
                    begin
                        total_next = '0;
                    end
                    else if (op_reg == REQ_REMOVE && !status_next)
                    begin
                        total_next = total_reg - T_W'(1);
                    end
                    else if (op_reg == REQ_ADD && !status_next &&
                             total_ext < CW'(MAX_ENTRIES))
                    begin
                        // An update of an existing entry leaves the count as it is; growth after an
                        // append is applied through appended_reg below.
                        total_next = total_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Add grows the table only when the new entry went into the free slot; that is
    // tracked separately from the update-in-place case.
    logic appended_reg, appended_next;

    always_comb
    begin
        appended_next = appended_reg;
        if (state_reg == ST_IDLE)
        begin
            appended_next = 1'b0;
        end
        else if (state_reg == ST_RUN && op_reg == REQ_ADD && len_reg != '0 &&
                 k_ext == total_ext && !found_reg)
        begin
            appended_next = 1'b1;
        end
    end

    logic [T_W-1:0] total_final;

    assign total_final = (load_out && appended_reg) ? total_reg + T_W'(1) : total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            matched_reg   <= 1'b0;
            appended_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            total_reg    <= total_final;
            found_reg    <= found_next;
            matched_reg  <= matched_next;
            appended_reg <= appended_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        if (accept)
        begin
            op_reg    <= req.req_type;
            dig_reg   <= dig_norm;
            len_reg   <= len_sat;
            exact_reg <= req.exact_flag;
            idx_reg   <= req.entry_index;
        end
        if (load_out)
        begin
            status_reg   <= status_next;
            rmatched_reg <= rmatched_next;
            rentry_reg   <= rentry_next;
            count_reg    <= COUNT_W'(total_final);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.matched      = rmatched_reg;
    assign rsp.entry_digits = rentry_reg.digits;
    assign rsp.entry_length = rentry_reg.length;
    assign rsp.entry_exact  = rentry_reg.exact;
    assign rsp.filter_count = count_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= T_W'(MAX_ENTRIES))
        else $error("filter count beyond table size");

    a_total_change: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> ($past(state_reg) == ST_FINISH))
        else $error("filter count changed outside request completion");

    a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (k_reg == '0))
        else $error("ring position not parked outside a turn");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("response beat raised without a finished request");

endmodule
